@@ rtl/sdhcs_pkg.sv @@
// Package for the SD host command sequencer: field widths, codes and reset values.
// Used by the channel interfaces and the sequencer top level; depends on nothing.

package sdhcs_pkg;

	// Field widths of the item and result channels.
	localparam int ActionW  = 2;
	localparam int EventW   = 3;
	localparam int WordW    = 32;
	localparam int CmdIdxW  = 6;
	localparam int StatusW  = 4;

	// Configuration register widths and the APB address width.
	localparam int PatternW   = 12;
	localparam int ProbeW     = 4;
	localparam int PollW      = 7;
	localparam int ReadTriesW = 3;
	localparam int RcaW       = 16;
	localparam int AddrW      = 5;

	// Item actions.
	localparam logic [ActionW-1:0] ACT_START = 2'd0;
	localparam logic [ActionW-1:0] ACT_READ  = 2'd1;
	localparam logic [ActionW-1:0] ACT_EVENT = 2'd2;

	// Bus event kinds.
	localparam logic [EventW-1:0] EV_RESP_OK      = 3'd0;
	localparam logic [EventW-1:0] EV_RESP_CRC     = 3'd1;
	localparam logic [EventW-1:0] EV_RESP_TIMEOUT = 3'd2;
	localparam logic [EventW-1:0] EV_CMD_SENT     = 3'd3;
	localparam logic [EventW-1:0] EV_DATA_READY   = 3'd4;
	localparam logic [EventW-1:0] EV_DATA_TIMEOUT = 3'd5;

	// Completion status codes.
	localparam logic [StatusW-1:0] ST_OK        = 4'd0;
	localparam logic [StatusW-1:0] ST_PROBE     = 4'd1;
	localparam logic [StatusW-1:0] ST_READY     = 4'd2;
	localparam logic [StatusW-1:0] ST_CID       = 4'd3;
	localparam logic [StatusW-1:0] ST_RCA       = 4'd4;
	localparam logic [StatusW-1:0] ST_SELECT    = 4'd5;
	localparam logic [StatusW-1:0] ST_READ_CMD  = 4'd6;
	localparam logic [StatusW-1:0] ST_READ_DATA = 4'd7;
	localparam logic [StatusW-1:0] ST_BUSY      = 4'd8;

	// SD command indexes.
	localparam logic [CmdIdxW-1:0] CMD_GO_IDLE       = 6'd0;
	localparam logic [CmdIdxW-1:0] CMD_ALL_SEND_CID  = 6'd2;
	localparam logic [CmdIdxW-1:0] CMD_SEND_RCA      = 6'd3;
	localparam logic [CmdIdxW-1:0] CMD_SET_BUS_WIDTH = 6'd6;
	localparam logic [CmdIdxW-1:0] CMD_SELECT        = 6'd7;
	localparam logic [CmdIdxW-1:0] CMD_SEND_IF_COND  = 6'd8;
	localparam logic [CmdIdxW-1:0] CMD_READ_SINGLE   = 6'd17;
	localparam logic [CmdIdxW-1:0] CMD_SD_SEND_OP    = 6'd41;
	localparam logic [CmdIdxW-1:0] CMD_APP           = 6'd55;

	// Configuration register indexes.
	localparam logic [2:0] REG_CHECK_PATTERN = 3'd0;
	localparam logic [2:0] REG_OCR_REQUEST   = 3'd1;
	localparam logic [2:0] REG_PROBE_TRIES   = 3'd2;
	localparam logic [2:0] REG_READY_POLLS   = 3'd3;
	localparam logic [2:0] REG_READ_TRIES    = 3'd4;

	// Register reset values.
	localparam logic [PatternW-1:0]   RST_CHECK_PATTERN = 12'h1AA;
	localparam logic [WordW-1:0]      RST_OCR_REQUEST   = 32'h40FF8000;
	localparam logic [ProbeW-1:0]     RST_PROBE_TRIES   = 4'd10;
	localparam logic [PollW-1:0]      RST_READY_POLLS   = 7'd100;
	localparam logic [ReadTriesW-1:0] RST_READ_TRIES    = 3'd5;

	// Argument of ACMD6 that selects the 4-bit bus.
	localparam logic [WordW-1:0] ARG_BUS_4BIT = 32'h2;

endpackage

@@ rtl/sdhcs_ifs.sv @@
// Valid/ready channel interfaces for the SD host command sequencer.
// Depends on sdhcs_pkg for field widths.

// Input item channel: action requests and bus events.
interface sdhcs_item_if;
	logic                             valid;
	logic                             ready;
	logic [sdhcs_pkg::ActionW-1:0]    action;
	logic [sdhcs_pkg::WordW-1:0]      block_addr;
	logic [sdhcs_pkg::EventW-1:0]     event_kind;
	logic [sdhcs_pkg::WordW-1:0]      resp_word;

	modport source (output valid, action, block_addr, event_kind, resp_word, input ready);
	modport sink (input valid, action, block_addr, event_kind, resp_word, output ready);
endinterface

// Result channel: command to issue and completion report.
interface sdhcs_result_if;
	logic                             valid;
	logic                             ready;
	logic                             issue_cmd;
	logic [sdhcs_pkg::CmdIdxW-1:0]    cmd_index;
	logic [sdhcs_pkg::WordW-1:0]      cmd_arg;
	logic                             want_response;
	logic                             long_response;
	logic                             ignore_crc;
	logic                             start_data;
	logic                             wide_bus;
	logic                             finished;
	logic [sdhcs_pkg::StatusW-1:0]    status;
	logic                             high_capacity;

	modport source (output valid, issue_cmd, cmd_index, cmd_arg, want_response,
		long_response, ignore_crc, start_data, wide_bus, finished, status,
		high_capacity, input ready);
	modport sink (input valid, issue_cmd, cmd_index, cmd_arg, want_response,
		long_response, ignore_crc, start_data, wide_bus, finished, status,
		high_capacity, output ready);
endinterface

@@ rtl/sd_host_command_sequencer.sv @@
// SD host command sequencer: card bring-up and single-block read command flow.
// Depends on sdhcs_pkg and the channel interfaces in sdhcs_ifs.sv.
// Two register stages (input s1, result s2); the result stage holds while result.ready
// is low. Throughput: one item per cycle while result.ready is high, set by the
// combinational phase update between the stages. Reset (arst_n low) clears the phase
// to idle, all counters and card state, and loads the configuration register defaults.

module sd_host_command_sequencer (
	input  logic                         clk,
	input  logic                         arst_n,
	sdhcs_item_if.sink                   item,
	sdhcs_result_if.source               result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sdhcs_pkg::AddrW-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	// Sequencer phases.
	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_CMD0   = 4'd1;
	localparam logic [3:0] PH_CMD8   = 4'd2;
	localparam logic [3:0] PH_CMD55  = 4'd3;
	localparam logic [3:0] PH_ACMD41 = 4'd4;
	localparam logic [3:0] PH_CMD2   = 4'd5;
	localparam logic [3:0] PH_CMD3   = 4'd6;
	localparam logic [3:0] PH_CMD7   = 4'd7;
	localparam logic [3:0] PH_CMD55W = 4'd8;
	localparam logic [3:0] PH_ACMD6  = 4'd9;
	localparam logic [3:0] PH_READY  = 4'd10;
	localparam logic [3:0] PH_CMD17  = 4'd11;
	localparam logic [3:0] PH_DATA   = 4'd12;

	// Configuration registers.
	logic [sdhcs_pkg::PatternW-1:0]   check_pattern_q;
	logic [sdhcs_pkg::WordW-1:0]      ocr_request_q;
	logic [sdhcs_pkg::ProbeW-1:0]     probe_tries_q;
	logic [sdhcs_pkg::PollW-1:0]      ready_polls_q;
	logic [sdhcs_pkg::ReadTriesW-1:0] read_tries_q;

	// Sequencer state.
	logic [3:0]                       phase_q;
	logic [sdhcs_pkg::PollW-1:0]      attempt_count_q;
	logic [sdhcs_pkg::ReadTriesW-1:0] read_attempts_q;
	logic                             block_mode_q;
	logic                             four_bit_mode_q;
	logic [sdhcs_pkg::RcaW-1:0]       card_address_q;
	logic [sdhcs_pkg::WordW-1:0]      pending_block_q;
	logic                             ready_flag_q;

	// Input stage.
	logic                             vld_s1;
	logic [sdhcs_pkg::ActionW-1:0]    action_s1;
	logic [sdhcs_pkg::WordW-1:0]      block_addr_s1;
	logic [sdhcs_pkg::EventW-1:0]     event_kind_s1;
	logic [sdhcs_pkg::WordW-1:0]      resp_word_s1;

	// Result stage.
	logic                             vld_s2;
	logic                             issue_cmd_s2;
	logic [sdhcs_pkg::CmdIdxW-1:0]    cmd_index_s2;
	logic [sdhcs_pkg::WordW-1:0]      cmd_arg_s2;
	logic                             want_response_s2;
	logic                             long_response_s2;
	logic                             ignore_crc_s2;
	logic                             start_data_s2;
	logic                             wide_bus_s2;
	logic                             finished_s2;
	logic [sdhcs_pkg::StatusW-1:0]    status_s2;
	logic                             high_capacity_s2;

	// Next-state and result logic.
	logic [3:0]                       n_phase;
	logic [sdhcs_pkg::PollW-1:0]      n_attempt_count;
	logic [sdhcs_pkg::ReadTriesW-1:0] n_read_attempts;
	logic                             n_block_mode;
	logic                             n_four_bit_mode;
	logic [sdhcs_pkg::RcaW-1:0]       n_card_address;
	logic [sdhcs_pkg::WordW-1:0]      n_pending_block;
	logic                             n_ready_flag;
	logic                             c_issue;
	logic [sdhcs_pkg::CmdIdxW-1:0]    c_index;
	logic [sdhcs_pkg::WordW-1:0]      c_arg;
	logic                             c_want;
	logic                             c_long;
	logic                             c_nocrc;
	logic                             c_start_data;
	logic                             c_wide;
	logic                             c_done;
	logic [sdhcs_pkg::StatusW-1:0]    c_done_st;
	logic [sdhcs_pkg::StatusW-1:0]    c_status;
	logic                             got_resp;
	logic                             resp_kind;
	logic                             read_retry;
	logic [sdhcs_pkg::StatusW-1:0]    read_fail_st;
	logic                             read_issue;
	logic [sdhcs_pkg::WordW-1:0]      read_arg;

	logic                             advance;
	logic                             cfg_write;

	// The result stage moves when it is empty or its transfer completes.
	assign advance    = !vld_s2 || result.ready;
	assign item.ready = !vld_s1 || advance;

	// Configuration port.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[sdhcs_pkg::AddrW-1:2])
			sdhcs_pkg::REG_CHECK_PATTERN: prdata = {20'd0, check_pattern_q};
			sdhcs_pkg::REG_OCR_REQUEST:   prdata = ocr_request_q;
			sdhcs_pkg::REG_PROBE_TRIES:   prdata = {28'd0, probe_tries_q};
			sdhcs_pkg::REG_READY_POLLS:   prdata = {25'd0, ready_polls_q};
			sdhcs_pkg::REG_READ_TRIES:    prdata = {29'd0, read_tries_q};
			default:                      prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_pattern_q <= sdhcs_pkg::RST_CHECK_PATTERN;
			ocr_request_q   <= sdhcs_pkg::RST_OCR_REQUEST;
			probe_tries_q   <= sdhcs_pkg::RST_PROBE_TRIES;
			ready_polls_q   <= sdhcs_pkg::RST_READY_POLLS;
			read_tries_q    <= sdhcs_pkg::RST_READ_TRIES;
		end else if (cfg_write) begin
			unique case (paddr[sdhcs_pkg::AddrW-1:2])
				sdhcs_pkg::REG_CHECK_PATTERN: check_pattern_q <= pwdata[11:0];
				sdhcs_pkg::REG_OCR_REQUEST:   ocr_request_q   <= pwdata;
				sdhcs_pkg::REG_PROBE_TRIES:   probe_tries_q   <= pwdata[3:0];
				sdhcs_pkg::REG_READY_POLLS:   ready_polls_q   <= pwdata[6:0];
				sdhcs_pkg::REG_READ_TRIES:    read_tries_q    <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	// Read command argument: block number, or byte address on a byte-addressed card.
	assign read_arg = block_mode_q ? n_pending_block : {n_pending_block[22:0], 9'd0};

	// Phase update and result for the item in the input stage.
	always_comb begin
		n_phase         = phase_q;
		n_attempt_count = attempt_count_q;
		n_read_attempts = read_attempts_q;
		n_block_mode    = block_mode_q;
		n_four_bit_mode = four_bit_mode_q;
		n_card_address  = card_address_q;
		n_pending_block = pending_block_q;
		n_ready_flag    = ready_flag_q;
		c_issue         = 1'b0;
		c_index         = sdhcs_pkg::CMD_GO_IDLE;
		c_arg           = '0;
		c_want          = 1'b1;
		c_long          = 1'b0;
		c_nocrc         = 1'b0;
		c_done          = 1'b0;
		c_done_st       = sdhcs_pkg::ST_OK;
		read_retry      = 1'b0;
		read_fail_st    = sdhcs_pkg::ST_READ_CMD;
		read_issue      = 1'b0;

		got_resp  = (event_kind_s1 == sdhcs_pkg::EV_RESP_OK) ||
			(event_kind_s1 == sdhcs_pkg::EV_RESP_CRC);
		resp_kind = got_resp || (event_kind_s1 == sdhcs_pkg::EV_RESP_TIMEOUT);

		case (action_s1)
			sdhcs_pkg::ACT_START: begin
				n_block_mode    = 1'b0;
				n_four_bit_mode = 1'b0;
				n_card_address  = '0;
				n_ready_flag    = 1'b0;
				n_attempt_count = '0;
				n_read_attempts = '0;
				c_issue         = 1'b1;
				c_index         = sdhcs_pkg::CMD_GO_IDLE;
				c_want          = 1'b0;
				n_phase         = PH_CMD0;
			end
			sdhcs_pkg::ACT_READ: begin
				if (phase_q != PH_READY || !ready_flag_q) begin
					c_done    = 1'b1;
					c_done_st = sdhcs_pkg::ST_BUSY;
				end else begin
					n_pending_block = block_addr_s1;
					n_read_attempts = 3'd1;
					read_issue      = 1'b1;
				end
			end
			sdhcs_pkg::ACT_EVENT: begin
				unique case (phase_q)
					PH_CMD0: begin
						if (event_kind_s1 == sdhcs_pkg::EV_RESP_TIMEOUT ||
							event_kind_s1 == sdhcs_pkg::EV_CMD_SENT) begin
							n_attempt_count = 7'd1;
							c_issue = 1'b1;
							c_index = sdhcs_pkg::CMD_SEND_IF_COND;
							c_arg   = {20'd0, check_pattern_q};
							n_phase = PH_CMD8;
						end
					end
					PH_CMD8: begin
						if (got_resp && resp_word_s1 == {20'd0, check_pattern_q}) begin
							n_attempt_count = 7'd1;
							c_issue = 1'b1;
							c_index = sdhcs_pkg::CMD_APP;
							n_phase = PH_CMD55;
						end else if (resp_kind) begin
							if (attempt_count_q >= {3'd0, probe_tries_q}) begin
								n_phase      = PH_IDLE;
								n_ready_flag = 1'b0;
								c_done       = 1'b1;
								c_done_st    = sdhcs_pkg::ST_PROBE;
							end else begin
								n_attempt_count = attempt_count_q + 7'd1;
								c_issue = 1'b1;
								c_index = sdhcs_pkg::CMD_SEND_IF_COND;
								c_arg   = {20'd0, check_pattern_q};
							end
						end
					end
					PH_CMD55: begin
						if (got_resp) begin
							c_issue = 1'b1;
							c_index = sdhcs_pkg::CMD_SD_SEND_OP;
							c_arg   = ocr_request_q;
							c_nocrc = 1'b1;
							n_phase = PH_ACMD41;
						end else if (event_kind_s1 == sdhcs_pkg::EV_RESP_TIMEOUT) begin
							n_phase      = PH_IDLE;
							n_ready_flag = 1'b0;
							c_done       = 1'b1;
							c_done_st    = sdhcs_pkg::ST_READY;
						end
					end
					PH_ACMD41: begin
						if (got_resp) begin
							if (resp_word_s1[31]) begin
								n_block_mode = resp_word_s1[30];
								c_issue = 1'b1;
								c_index = sdhcs_pkg::CMD_ALL_SEND_CID;
								c_long  = 1'b1;
								n_phase = PH_CMD2;
							end else if (attempt_count_q >= ready_polls_q) begin
								n_phase      = PH_IDLE;
								n_ready_flag = 1'b0;
								c_done       = 1'b1;
								c_done_st    = sdhcs_pkg::ST_READY;
							end else begin
								n_attempt_count = attempt_count_q + 7'd1;
								c_issue = 1'b1;
								c_index = sdhcs_pkg::CMD_APP;
								n_phase = PH_CMD55;
							end
						end else if (event_kind_s1 == sdhcs_pkg::EV_RESP_TIMEOUT) begin
							n_phase      = PH_IDLE;
							n_ready_flag = 1'b0;
							c_done       = 1'b1;
							c_done_st    = sdhcs_pkg::ST_READY;
						end
					end
					PH_CMD2: begin
						// Only a response with a good CRC counts for the CID.
						if (event_kind_s1 == sdhcs_pkg::EV_RESP_OK) begin
							c_issue = 1'b1;
							c_index = sdhcs_pkg::CMD_SEND_RCA;
							n_phase = PH_CMD3;
						end else if (resp_kind) begin
							n_phase      = PH_IDLE;
							n_ready_flag = 1'b0;
							c_done       = 1'b1;
							c_done_st    = sdhcs_pkg::ST_CID;
						end
					end
					PH_CMD3: begin
						if (got_resp) begin
							n_card_address = resp_word_s1[31:16];
							c_issue = 1'b1;
							c_index = sdhcs_pkg::CMD_SELECT;
							c_arg   = {resp_word_s1[31:16], 16'd0};
							n_phase = PH_CMD7;
						end else if (event_kind_s1 == sdhcs_pkg::EV_RESP_TIMEOUT) begin
							n_phase      = PH_IDLE;
							n_ready_flag = 1'b0;
							c_done       = 1'b1;
							c_done_st    = sdhcs_pkg::ST_RCA;
						end
					end
					PH_CMD7: begin
						if (got_resp) begin
							c_issue = 1'b1;
							c_index = sdhcs_pkg::CMD_APP;
							c_arg   = {card_address_q, 16'd0};
							n_phase = PH_CMD55W;
						end else if (event_kind_s1 == sdhcs_pkg::EV_RESP_TIMEOUT) begin
							n_phase      = PH_IDLE;
							n_ready_flag = 1'b0;
							c_done       = 1'b1;
							c_done_st    = sdhcs_pkg::ST_SELECT;
						end
					end
					PH_CMD55W: begin
						if (got_resp) begin
							c_issue = 1'b1;
							c_index = sdhcs_pkg::CMD_SET_BUS_WIDTH;
							c_arg   = sdhcs_pkg::ARG_BUS_4BIT;
							n_phase = PH_ACMD6;
						end else if (event_kind_s1 == sdhcs_pkg::EV_RESP_TIMEOUT) begin
							// The card keeps the 1-bit bus; init still succeeds.
							n_phase      = PH_READY;
							n_ready_flag = 1'b1;
							c_done       = 1'b1;
						end
					end
					PH_ACMD6: begin
						if (got_resp || event_kind_s1 == sdhcs_pkg::EV_RESP_TIMEOUT) begin
							n_four_bit_mode = got_resp ? 1'b1 : four_bit_mode_q;
							n_phase      = PH_READY;
							n_ready_flag = 1'b1;
							c_done       = 1'b1;
						end
					end
					PH_CMD17: begin
						if (event_kind_s1 == sdhcs_pkg::EV_RESP_OK) begin
							n_phase = PH_DATA;
						end else if (event_kind_s1 == sdhcs_pkg::EV_RESP_CRC ||
							event_kind_s1 == sdhcs_pkg::EV_RESP_TIMEOUT) begin
							read_retry   = 1'b1;
							read_fail_st = sdhcs_pkg::ST_READ_CMD;
						end
					end
					PH_DATA: begin
						if (event_kind_s1 == sdhcs_pkg::EV_DATA_READY) begin
							n_phase = PH_READY;
							c_done  = 1'b1;
						end else if (event_kind_s1 == sdhcs_pkg::EV_DATA_TIMEOUT) begin
							read_retry   = 1'b1;
							read_fail_st = sdhcs_pkg::ST_READ_DATA;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		// A failed read attempt either retries or gives up with its status.
		if (read_retry) begin
			if (read_attempts_q >= read_tries_q) begin
				n_phase   = PH_READY;
				c_done    = 1'b1;
				c_done_st = read_fail_st;
			end else begin
				n_read_attempts = read_attempts_q + 3'd1;
				read_issue      = 1'b1;
			end
		end

		c_start_data = 1'b0;
		c_wide       = 1'b0;
		if (read_issue) begin
			c_issue      = 1'b1;
			c_index      = sdhcs_pkg::CMD_READ_SINGLE;
			c_arg        = read_arg;
			c_start_data = 1'b1;
			c_wide       = four_bit_mode_q;
			n_phase      = PH_CMD17;
		end

		if (c_done) begin
			c_status = c_done_st;
		end else if (n_phase != PH_IDLE && n_phase != PH_READY) begin
			c_status = sdhcs_pkg::ST_BUSY;
		end else begin
			c_status = sdhcs_pkg::ST_OK;
		end
	end

	// Input register and state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1          <= 1'b0;
			vld_s2          <= 1'b0;
			phase_q         <= PH_IDLE;
			attempt_count_q <= '0;
			read_attempts_q <= '0;
			block_mode_q    <= 1'b0;
			four_bit_mode_q <= 1'b0;
			card_address_q  <= '0;
			pending_block_q <= '0;
			ready_flag_q    <= 1'b0;
		end else begin
			if (item.ready) begin
				vld_s1 <= item.valid;
			end
			if (advance) begin
				vld_s2 <= vld_s1;
				if (vld_s1) begin
					phase_q         <= n_phase;
					attempt_count_q <= n_attempt_count;
					read_attempts_q <= n_read_attempts;
					block_mode_q    <= n_block_mode;
					four_bit_mode_q <= n_four_bit_mode;
					card_address_q  <= n_card_address;
					pending_block_q <= n_pending_block;
					ready_flag_q    <= n_ready_flag;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			action_s1     <= item.action;
			block_addr_s1 <= item.block_addr;
			event_kind_s1 <= item.event_kind;
			resp_word_s1  <= item.resp_word;
		end
		if (advance && vld_s1) begin
			issue_cmd_s2     <= c_issue;
			cmd_index_s2     <= c_issue ? c_index : '0;
			cmd_arg_s2       <= c_issue ? c_arg : '0;
			want_response_s2 <= c_issue && c_want;
			long_response_s2 <= c_issue && c_long;
			ignore_crc_s2    <= c_issue && c_nocrc;
			start_data_s2    <= c_start_data;
			wide_bus_s2      <= c_wide;
			finished_s2      <= c_done;
			status_s2        <= c_status;
			high_capacity_s2 <= n_block_mode;
		end
	end

	assign result.valid         = vld_s2;
	assign result.issue_cmd     = issue_cmd_s2;
	assign result.cmd_index     = cmd_index_s2;
	assign result.cmd_arg       = cmd_arg_s2;
	assign result.want_response = want_response_s2;
	assign result.long_response = long_response_s2;
	assign result.ignore_crc    = ignore_crc_s2;
	assign result.start_data    = start_data_s2;
	assign result.wide_bus      = wide_bus_s2;
	assign result.finished      = finished_s2;
	assign result.status        = status_s2;
	assign result.high_capacity = high_capacity_s2;

endmodule
